FILE: rtl/affba_pkg.sv
package affba_pkg;

    // Table geometry defaults
    localparam int NUM_BLOCKS_DEF  = 1024;
    localparam int BLOCK_BYTES_DEF = 4096;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 32;
    localparam int ALIGN_W    = 5;
    localparam int OPCODE_W   = 1;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b1;

endpackage

FILE: rtl/aligned_first_fit_block_allocator.sv
// Aligned first-fit block allocator. The block table holds a used bit and a
// continues bit for each block of BLOCK_BYTES bytes (a power of two) and sits
// in one memory with a single read and a single write port; the scan reads
// one entry per cycle. After reset a clearing pass zeroes every table entry,
// and no request is taken until it ends. An allocate first scans the table
// entries in order, up to the managed count, and then marks each block of the
// granted run. A zero size or an uninitialized table answers without a scan.
// A free releases each block of the chain, one table write per block. One
// request is in work at a time; the result sits in an output register, so
// the next request is taken while a result waits to transfer.
module aligned_first_fit_block_allocator
#(
    parameter int NUM_BLOCKS  = affba_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = affba_pkg::BLOCK_BYTES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [affba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [affba_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [affba_pkg::OPCODE_W-1:0]      opcode,
    input  logic [affba_pkg::SIZE_W-1:0]        size_bytes,
    input  logic [affba_pkg::ALIGN_W-1:0]       align_log2,
    input  logic [affba_pkg::ADDR_W-1:0]        free_address,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [affba_pkg::ADDR_W-1:0]        granted_address,
    output logic [affba_pkg::STATUS_W-1:0]      status
);
    import affba_pkg::*;

    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int BLOCK_LOG2 = $clog2(BLOCK_BYTES);
    localparam int NEED_W     = SIZE_W + 1 - BLOCK_LOG2;
    localparam int BN_W       = ADDR_W - BLOCK_LOG2;
    localparam int NC_W       = (NEED_W > CNT_W) ? NEED_W : CNT_W;
    localparam int BC_W       = (BN_W > CNT_W) ? BN_W : CNT_W;
    localparam int MC_W       = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_PREP,
        S_SCAN,
        S_MARK,
        S_FREE_PREP,
        S_CHAIN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic used;
        logic cont;
    } entry_t;

    // Block table
    entry_t mem [NUM_BLOCKS];
    entry_t rd_data_reg;
    logic   wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t wr_data;
    logic [IDX_W-1:0] rd_idx;

    // Control and working registers
    state_t state_reg, state_next;
    logic [ADDR_W-1:0]  region_base_reg, region_base_next;
    logic [COUNT_W-1:0] blocks_reg, blocks_next;
    logic [IDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [ALIGN_W-1:0] align_reg, align_next;
    logic [ADDR_W-1:0]  free_addr_reg, free_addr_next;
    logic [ADDR_W-1:0]  mask_reg, mask_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   eval_reg, eval_next;
    logic [CNT_W-1:0]   need_reg, need_next;
    logic [CNT_W-1:0]   last_start_reg, last_start_next;
    logic               run_reg, run_next;
    logic [CNT_W-1:0]   run_cnt_reg, run_cnt_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   mark_idx_reg, mark_idx_next;
    logic [CNT_W-1:0]   mark_left_reg, mark_left_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  granted_reg, granted_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Derived values
    logic [CNT_W-1:0]   n_cnt;
    logic [MC_W-1:0]    blocks_ext;
    logic [SIZE_W:0]    size_round;
    logic [NEED_W-1:0]  need_wide;
    logic [ADDR_W-1:0]  offset;
    logic [BN_W-1:0]    bn_wide;
    logic [CNT_W:0]     eval_plus;
    logic [CNT_W-1:0]   run_cnt_plus;
    logic               aligned;

    // Clamp the managed count to the table depth
    assign blocks_ext = MC_W'(blocks_reg);
    assign n_cnt = (blocks_ext > MC_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_reg);

    // Round the size up to whole blocks
    assign size_round = {1'b0, size_reg} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
    assign need_wide  = size_round[SIZE_W:BLOCK_LOG2];

    // Block number of a free address
    assign offset  = free_addr_reg - region_base_reg;
    assign bn_wide = offset[ADDR_W-1:BLOCK_LOG2];

    assign eval_plus    = {1'b0, eval_reg} + (CNT_W + 1)'(1);
    assign run_cnt_plus = run_cnt_reg + CNT_W'(1);
    assign aligned      = (addr_reg & mask_reg) == '0;

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign granted_address = granted_reg;
    assign status          = status_reg;

    // Sequence one request over the shared table port
    always_comb
    begin
        state_next      = state_reg;
        region_base_next = region_base_reg;
        blocks_next     = blocks_reg;
        clr_idx_next    = clr_idx_reg;
        size_next       = size_reg;
        align_next      = align_reg;
        free_addr_next  = free_addr_reg;
        mask_next       = mask_reg;
        addr_next       = addr_reg;
        eval_next       = eval_reg;
        need_next       = need_reg;
        last_start_next = last_start_reg;
        run_next        = run_reg;
        run_cnt_next    = run_cnt_reg;
        start_next      = start_reg;
        mark_idx_next   = mark_idx_reg;
        mark_left_next  = mark_left_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        granted_next    = granted_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_idx          = IDX_W'(eval_reg);
        wr_data         = '0;
        rd_idx          = IDX_W'(eval_plus);

        // Take configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REGION_BASE:   region_base_next = cfg_data;
                REG_BLOCKS_IN_USE: blocks_next = cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en  = 1'b1;
                wr_idx = clr_idx_reg;
                if (clr_idx_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    size_next       = size_bytes;
                    align_next      = align_log2;
                    free_addr_next  = free_address;
                    if (opcode == OP_ALLOC)
                    begin
                        if (size_bytes == '0)
                        begin
                            res_status_next = ST_ZERO;
                            state_next      = S_RESP;
                        end
                        else if (n_cnt == '0)
                        begin
                            res_status_next = ST_NOSPACE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_ALLOC_PREP;
                        end
                    end
                    else
                    begin
                        if (n_cnt == '0)
                        begin
                            res_status_next = ST_NOSPACE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_FREE_PREP;
                        end
                    end
                end
            end

            S_ALLOC_PREP:
            begin
                // prime the read of entry zero and set up the scan
                rd_idx    = '0;
                mask_next = ADDR_W'((33'd1 << align_reg) - 33'd1);
                addr_next = region_base_reg;
                eval_next = '0;
                run_next  = 1'b0;
                if (NC_W'(need_wide) > NC_W'(n_cnt))
                begin
                    res_status_next = ST_NOSPACE;
                    state_next      = S_RESP;
                end
                else
                begin
                    need_next       = CNT_W'(need_wide);
                    last_start_next = n_cnt - CNT_W'(need_wide);
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!run_reg)
                begin
                    if (eval_reg == n_cnt)
                    begin
                        res_addr_next   = '0;
                        res_status_next = ST_NOSPACE;
                        state_next      = S_RESP;
                    end
                    else if (!rd_data_reg.used && aligned)
                    begin
                        if (eval_reg > last_start_reg)
                        begin
                            res_addr_next   = '0;
                            res_status_next = ST_NOSPACE;
                            state_next      = S_RESP;
                        end
                        else if (need_reg == CNT_W'(1))
                        begin
                            res_addr_next  = addr_reg;
                            mark_idx_next  = IDX_W'(eval_reg);
                            mark_left_next = '0;
                            state_next     = S_MARK;
                        end
                        else
                        begin
                            res_addr_next = addr_reg;
                            start_next    = IDX_W'(eval_reg);
                            run_next      = 1'b1;
                            run_cnt_next  = CNT_W'(1);
                            eval_next     = CNT_W'(eval_plus);
                            addr_next     = addr_reg + ADDR_W'(BLOCK_BYTES);
                        end
                    end
                    else
                    begin
                        eval_next = CNT_W'(eval_plus);
                        addr_next = addr_reg + ADDR_W'(BLOCK_BYTES);
                    end
                end
                else
                begin
                    if (rd_data_reg.used)
                    begin
                        // run broken: resume the search past this block
                        run_next  = 1'b0;
                        eval_next = CNT_W'(eval_plus);
                        addr_next = addr_reg + ADDR_W'(BLOCK_BYTES);
                    end
                    else if (run_cnt_plus == need_reg)
                    begin
                        mark_idx_next  = start_reg;
                        mark_left_next = need_reg - CNT_W'(1);
                        run_next       = 1'b0;
                        state_next     = S_MARK;
                    end
                    else
                    begin
                        run_cnt_next = run_cnt_plus;
                        eval_next    = CNT_W'(eval_plus);
                        addr_next    = addr_reg + ADDR_W'(BLOCK_BYTES);
                    end
                end
            end

            S_MARK:
            begin
                wr_en        = 1'b1;
                wr_idx       = mark_idx_reg;
                wr_data.used = 1'b1;
                wr_data.cont = (mark_left_reg != '0);
                if (mark_left_reg == '0)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                end
                else
                begin
                    mark_idx_next  = mark_idx_reg + IDX_W'(1);
                    mark_left_next = mark_left_reg - CNT_W'(1);
                end
            end

            S_FREE_PREP:
            begin
                rd_idx = IDX_W'(bn_wide);
                if (BC_W'(bn_wide) >= BC_W'(n_cnt))
                begin
                    res_status_next = ST_OUTSIDE;
                    state_next      = S_RESP;
                end
                else
                begin
                    eval_next  = CNT_W'(bn_wide);
                    state_next = S_CHAIN;
                end
            end

            S_CHAIN:
            begin
                // release this block, follow the chain up to the last one
                wr_en = 1'b1;
                if (rd_data_reg.cont && (eval_plus < {1'b0, n_cnt}))
                begin
                    eval_next = CNT_W'(eval_plus);
                end
                else
                begin
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = res_addr_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            region_base_reg <= '0;
            blocks_reg      <= '0;
            clr_idx_reg     <= '0;
            size_reg        <= '0;
            align_reg       <= '0;
            free_addr_reg   <= '0;
            mask_reg        <= '0;
            addr_reg        <= '0;
            eval_reg        <= '0;
            need_reg        <= '0;
            last_start_reg  <= '0;
            run_reg         <= 1'b0;
            run_cnt_reg     <= '0;
            start_reg       <= '0;
            mark_idx_reg    <= '0;
            mark_left_reg   <= '0;
            res_addr_reg    <= '0;
            res_status_reg  <= ST_OK;
            out_valid_reg   <= 1'b0;
            granted_reg     <= '0;
            status_reg      <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            region_base_reg <= region_base_next;
            blocks_reg      <= blocks_next;
            clr_idx_reg     <= clr_idx_next;
            size_reg        <= size_next;
            align_reg       <= align_next;
            free_addr_reg   <= free_addr_next;
            mask_reg        <= mask_next;
            addr_reg        <= addr_next;
            eval_reg        <= eval_next;
            need_reg        <= need_next;
            last_start_reg  <= last_start_next;
            run_reg         <= run_next;
            run_cnt_reg     <= run_cnt_next;
            start_reg       <= start_next;
            mark_idx_reg    <= mark_idx_next;
            mark_left_reg   <= mark_left_next;
            res_addr_reg    <= res_addr_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            granted_reg     <= granted_next;
            status_reg      <= status_next;
        end
    end

    // Block table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

`ifndef ASSERT_OFF
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (granted_address == '0))
        else $error("failed request carries a nonzero address");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !run_reg) |-> (eval_reg <= n_cnt))
        else $error("scan ran past the managed count");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && run_reg) |->
            ((run_cnt_reg != '0) && (run_cnt_reg < need_reg)))
        else $error("run count out of range");

    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && (!out_valid_reg || !out_stall)) |=>
            (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule

FILE: verif/alloc_result_checker.sv
module alloc_result_checker
#(
    parameter int NUM_BLOCKS  = affba_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = affba_pkg::BLOCK_BYTES_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [affba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [affba_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [affba_pkg::OPCODE_W-1:0]      opcode,
    input  logic [affba_pkg::SIZE_W-1:0]        size_bytes,
    input  logic [affba_pkg::ALIGN_W-1:0]       align_log2,
    input  logic [affba_pkg::ADDR_W-1:0]        free_address,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [affba_pkg::ADDR_W-1:0]        granted_address,
    input  logic [affba_pkg::STATUS_W-1:0]      status,
    output int                                  mismatch_count,
    output int                                  results_outstanding
);

    import affba_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [STATUS_W-1:0] st;
    } alloc_result_t;

    // Shadow copy of the block table and the two registers
    logic                used_map  [NUM_BLOCKS];
    logic                chain_map [NUM_BLOCKS];
    logic [ADDR_W-1:0]   base_reg;
    logic [COUNT_W-1:0]  count_reg;

    alloc_result_t       expected_results [$];
    alloc_result_t       got;
    alloc_result_t       want;
    int                  errors_seen = 0;

    // Counts above the table size saturate at the table size
    function automatic longint unsigned managed_blocks();
        return (count_reg > NUM_BLOCKS) ? NUM_BLOCKS : count_reg;
    endfunction

    // Byte address of a block, wrapping at 32 bits
    function automatic logic [ADDR_W-1:0] block_addr(input longint unsigned bn);
        longint unsigned a;
        a = base_reg;
        a = a + bn * BLOCK_BYTES;
        return a[ADDR_W-1:0];
    endfunction

    // First fit over aligned free blocks; claim and chain the run on success
    function automatic alloc_result_t predict_allocate(input logic [SIZE_W-1:0] size,
                                                       input logic [ALIGN_W-1:0] align);
        alloc_result_t   r;
        longint unsigned n;
        longint unsigned sz;
        longint unsigned need;
        longint unsigned mask;
        longint unsigned i;
        longint unsigned j;
        r.addr = '0;
        r.st   = ST_NOSPACE;
        n      = managed_blocks();
        if (size == '0) begin
            r.st = ST_ZERO;
            return r;
        end
        if (n == 0)
            return r;
        sz   = size;
        need = (sz + BLOCK_BYTES - 1) / BLOCK_BYTES;
        mask = (64'd1 << align) - 64'd1;
        for (i = 0; i < n; i++) begin
            if (!used_map[i] && ((block_addr(i) & mask) == 0)) begin
                if (i + need > n)
                    break;
                for (j = i; j < i + need; j++)
                    if (used_map[j])
                        break;
                if (j == i + need) begin
                    for (j = 0; j < need; j++) begin
                        used_map[i + j]  = 1'b1;
                        chain_map[i + j] = (j + 1 < need);
                    end
                    r.addr = block_addr(i);
                    r.st   = ST_OK;
                    return r;
                end
                // skip past the used block that broke the run
                i = j;
            end
        end
        return r;
    endfunction

    // Release the run that starts at the addressed block by walking its chain
    function automatic alloc_result_t predict_release(input logic [ADDR_W-1:0] addr);
        alloc_result_t   r;
        longint unsigned n;
        longint unsigned bn;
        logic [ADDR_W-1:0] offs;
        r.addr = '0;
        r.st   = ST_NOSPACE;
        n      = managed_blocks();
        if (n == 0)
            return r;
        offs = addr - base_reg;
        bn   = offs;
        bn   = bn / BLOCK_BYTES;
        if (bn >= n) begin
            r.st = ST_OUTSIDE;
            return r;
        end
        while (chain_map[bn] && (bn + 1 < n)) begin
            used_map[bn]  = 1'b0;
            chain_map[bn] = 1'b0;
            bn++;
        end
        used_map[bn]  = 1'b0;
        chain_map[bn] = 1'b0;
        r.st = ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input alloc_result_t got_r,
                                   input alloc_result_t want_r);
        errors_seen++;
        if (errors_seen <= 10)
            $display("%0t: %s: got granted_address %h status %0d, expected %h status %0d",
                     $time, what, got_r.addr, got_r.st, want_r.addr, want_r.st);
    endtask

    // Compare result transfers first, then predict the request transfer of the same edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                used_map[b]  = 1'b0;
                chain_map[b] = 1'b0;
            end
            base_reg  = '0;
            count_reg = '0;
            expected_results.delete();
            results_outstanding <= 0;
            mismatch_count      <= errors_seen;
        end else begin
            if (out_valid && !out_stall) begin
                got.addr = granted_address;
                got.st   = status;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", got, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.addr !== want.addr || got.st !== want.st)
                        report_mismatch("result mismatch", got, want);
                end
            end
            if (in_valid && !in_stall) begin
                if (opcode == OP_ALLOC)
                    expected_results.push_back(predict_allocate(size_bytes, align_log2));
                else
                    expected_results.push_back(predict_release(free_address));
            end
            if (cfg_we) begin
                if (cfg_index == REG_REGION_BASE)
                    base_reg = cfg_data;
                else if (cfg_index == REG_BLOCKS_IN_USE)
                    count_reg = cfg_data[COUNT_W-1:0];
            end
            results_outstanding <= expected_results.size();
            mismatch_count      <= errors_seen;
        end
    end

endmodule

FILE: verif/tb_aligned_first_fit_block_allocator.sv
module tb_aligned_first_fit_block_allocator;

    import affba_pkg::*;

    localparam int NB           = NUM_BLOCKS_DEF;
    localparam int BB           = BLOCK_BYTES_DEF;
    localparam int CYCLE_LIMIT  = 8000000;
    localparam int SETTLE_TICKS = 2 * NB + 16;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [OPCODE_W-1:0]    opcode;
    logic [SIZE_W-1:0]      size_bytes;
    logic [ALIGN_W-1:0]     align_log2;
    logic [ADDR_W-1:0]      free_address;
    logic                   out_valid;
    logic                   out_stall;
    logic [ADDR_W-1:0]      granted_address;
    logic [STATUS_W-1:0]    status;

    int                     mismatch_count;
    int                     results_outstanding;
    int                     idle_pct;
    int                     stall_pct;
    int                     cycle_count = 0;
    logic [ADDR_W-1:0]      cur_base;
    int                     cur_count;

    // Addresses handed out so far, used as targets for frees
    logic [ADDR_W-1:0]      grant_pool [$];
    logic [OPCODE_W-1:0]    ops_in_flight [$];
    logic [OPCODE_W-1:0]    done_op;

    aligned_first_fit_block_allocator #(
        .NUM_BLOCKS  (NB),
        .BLOCK_BYTES (BB)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .size_bytes      (size_bytes),
        .align_log2      (align_log2),
        .free_address    (free_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_address (granted_address),
        .status          (status)
    );

    alloc_result_checker #(
        .NUM_BLOCKS  (NB),
        .BLOCK_BYTES (BB)
    ) u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode              (opcode),
        .size_bytes          (size_bytes),
        .align_log2          (align_log2),
        .free_address        (free_address),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .granted_address     (granted_address),
        .status              (status),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Random receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Collect granted addresses so later frees hit live runs
    always @(posedge clk) begin
        if (out_valid && !out_stall && ops_in_flight.size() != 0) begin
            done_op = ops_in_flight.pop_front();
            if (done_op == OP_ALLOC && status == ST_OK)
                grant_pool.push_back(granted_address);
        end
        if (in_valid && !in_stall)
            ops_in_flight.push_back(opcode);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one request and hold it until the transfer
    task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [SIZE_W-1:0] sz,
                            input logic [ALIGN_W-1:0] al, input logic [ADDR_W-1:0] fa);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        size_bytes   <= sz;
        align_log2   <= al;
        free_address <= fa;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold off requests until every result has transferred
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [ADDR_W-1:0] base, input int count);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REGION_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_BLOCKS_IN_USE;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_base  = base;
        cur_count = count;
    endtask

    // Mostly small allocations and frees of live runs, with some noise
    task automatic send_random_item();
        int                pick;
        int                idx;
        logic [SIZE_W-1:0] sz;
        logic [ALIGN_W-1:0] al;
        logic [ADDR_W-1:0] fa;
        sz = $urandom;
        al = ALIGN_W'($urandom);
        fa = $urandom;
        if ($urandom_range(99) < 52) begin
            pick = $urandom_range(99);
            if (pick < 60)
                sz = $urandom_range(3 * BB, 1);
            else if (pick < 75)
                sz = $urandom_range(4, 1) * BB;
            else if (pick < 85)
                sz = $urandom_range(64 * BB, 1);
            else if (pick < 92)
                sz = $urandom;
            else
                sz = '0;
            pick = $urandom_range(99);
            if (pick < 75)
                al = ALIGN_W'($urandom_range(12, 0));
            else if (pick < 90)
                al = ALIGN_W'($urandom_range(16, 13));
            else
                al = ALIGN_W'($urandom_range(31, 0));
            send_req(OP_ALLOC, sz, al, fa);
        end else begin
            pick = $urandom_range(99);
            if (pick < 75 && grant_pool.size() != 0) begin
                idx = $urandom_range(grant_pool.size() - 1);
                fa  = grant_pool[idx];
                grant_pool.delete(idx);
                if ($urandom_range(3) == 0)
                    fa = fa + $urandom_range(BB - 1);
            end else if (pick < 90) begin
                // a few land just past the managed count
                fa = cur_base + $urandom_range(cur_count + 2) * BB;
            end
            send_req(OP_FREE, sz, al, fa);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] pb;
        int                pc;
        int                n_items;
        logic [ADDR_W-1:0] b;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_REGION_BASE;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        opcode       <= OP_ALLOC;
        size_bytes   <= '0;
        align_log2   <= '0;
        free_address <= '0;
        idle_pct     = 0;
        stall_pct    = 0;
        cur_base     = '0;
        cur_count    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Uninitialized table: zero size, then no space, then a free
        send_req(OP_ALLOC, '0, '0, $urandom);
        send_req(OP_ALLOC, 32'd100, '0, $urandom);
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), '0);

        // Small table for exact first-fit placements
        b = 32'h0010_0000;
        wait_all_results();
        write_config(b, 16);
        send_req(OP_ALLOC, 32'd1, 5'd0, $urandom);
        send_req(OP_ALLOC, BB, 5'd0, $urandom);
        send_req(OP_ALLOC, BB + 1, 5'd12, $urandom);
        send_req(OP_ALLOC, 32'hFFFF_FFFF, 5'd31, $urandom);
        send_req(OP_ALLOC, 32'd1, 5'd14, $urandom);
        send_req(OP_ALLOC, 8 * BB, 5'd0, $urandom);
        // run would cross the end of the table
        send_req(OP_ALLOC, 4 * BB, 5'd0, $urandom);
        // free from inside a block, then free the same block again
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), b + 2 * BB + 123);
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), b + 2 * BB);
        // below the base wraps to a huge offset; then past the end
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), b - 1);
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), b + 16 * BB);
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), 32'hFFFF_FFFF);
        send_req(OP_ALLOC, 3 * BB, 5'd0, $urandom);
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), b + 5 * BB);

        // Shrink the count so a chain runs into the last managed block
        wait_all_results();
        write_config(b, 14);
        send_req(OP_FREE, $urandom, ALIGN_W'($urandom), b + 13 * BB);

        // Count above the table size, with an alignment no block meets
        wait_all_results();
        write_config(b, 2047);
        send_req(OP_ALLOC, 32'd1, 5'd31, $urandom);

        // Random phases with different settings and idling
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin pb = 32'h0000_0000; pc = NB;   idle_pct = 0;  stall_pct = 0;
                         n_items = 120; end
                1: begin pb = 32'hFFFF_FC00; pc = 64;   idle_pct = 82; stall_pct = 0;
                         n_items = 110; end
                2: begin pb = 32'h1000_0000; pc = 200;  idle_pct = 0;  stall_pct = 82;
                         n_items = 110; end
                3: begin pb = 32'h8000_0400; pc = 2047; idle_pct = 37; stall_pct = 37;
                         n_items = 110; end
                4: begin pb = 32'h0003_0000; pc = 1;    idle_pct = 37; stall_pct = 37;
                         n_items = 30; end
                default: begin pb = 32'h0000_0000; pc = NB; idle_pct = 0; stall_pct = 0;
                         n_items = 100; end
            endcase
            wait_all_results();
            write_config(pb, pc);
            for (int k = 0; k < n_items; k++)
                send_random_item();
        end

        // Drain, then watch for stray results
        wait_all_results();
        stall_pct = 0;
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
